// ===== rtl/core/pgns_pkg.sv =====
// Shared types, codes and limit check for the prism grid neighbor step.
// No dependencies.
`default_nettype none
package pgns_pkg;

  localparam int CW = 16;
  localparam int DW = 4;
  localparam int BW = 3;
  localparam int IW = 3;

  typedef enum logic [1:0] {
    MODE_SQUARE = 2'd0,
    MODE_POINTY = 2'd1,
    MODE_FLAT   = 2'd2,
    MODE_TRI    = 2'd3
  } grid_mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SRC_OUT  = 2'd1,
    ST_BAD_DIR  = 2'd2,
    ST_DST_OUT  = 2'd3
  } status_t;

  localparam logic [IW-1:0] REG_GRID_MODE   = 3'd0;
  localparam logic [IW-1:0] REG_BOUNDS_EN   = 3'd1;
  localparam logic [IW-1:0] REG_LOWER_X     = 3'd2;
  localparam logic [IW-1:0] REG_UPPER_X     = 3'd3;
  localparam logic [IW-1:0] REG_LOWER_Y     = 3'd4;
  localparam logic [IW-1:0] REG_UPPER_Y     = 3'd5;
  localparam logic [IW-1:0] REG_LOWER_LAYER = 3'd6;
  localparam logic [IW-1:0] REG_UPPER_LAYER = 3'd7;

  localparam logic [DW-1:0] BASE_SQUARE = 4'd4;
  localparam logic [DW-1:0] BASE_HEX    = 4'd6;
  localparam logic [DW-1:0] BASE_TRI    = 4'd3;

  typedef struct packed {
    logic            enabled;
    logic signed [CW-1:0] lo_x;
    logic signed [CW-1:0] hi_x;
    logic signed [CW-1:0] lo_y;
    logic signed [CW-1:0] hi_y;
    logic signed [CW-1:0] lo_z;
    logic signed [CW-1:0] hi_z;
  } bounds_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
    logic [BW-1:0]     back;
    status_t           status;
  } move_t;

  function automatic logic in_box(input bounds_t b, input logic signed [CW-1:0] x,
                                  input logic signed [CW-1:0] y,
                                  input logic signed [CW-1:0] z);
    logic ok;
    ok = (z >= b.lo_z) && (z <= b.hi_z) && (x >= b.lo_x) && (x <= b.hi_x) &&
         (y >= b.lo_y) && (y <= b.hi_y);
    return !b.enabled || ok;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pgns_move.sv =====
// Step decode: offset, back direction and early status for one request.
// Depends on pgns_pkg.
`default_nettype none
module pgns_move (
  input  pgns_pkg::grid_mode_t            mode,
  input  logic [pgns_pkg::DW-1:0]         dir,
  input  logic                            tri_up,
  input  logic                            src_ok,
  output pgns_pkg::move_t                 mv
);
  import pgns_pkg::*;

  logic [DW-1:0] base;

  always_comb begin
    case (mode)
      MODE_SQUARE: base = BASE_SQUARE;
      MODE_TRI:    base = BASE_TRI;
      default:     base = BASE_HEX;
    endcase
  end

  always_comb begin
    mv.dx     = 2'sd0;
    mv.dy     = 2'sd0;
    mv.dz     = 2'sd0;
    mv.back   = '0;
    mv.status = ST_OK;
    if (!src_ok) begin
      mv.status = ST_SRC_OUT;
    end else if (dir > base + 4'd1) begin
      mv.status = ST_BAD_DIR;
    end else if (dir == base) begin
      mv.dz   = 2'sd1;
      mv.back = BW'(base + 4'd1);
    end else if (dir == base + 4'd1) begin
      mv.dz   = -2'sd1;
      mv.back = BW'(base);
    end else begin
      case (mode)
        MODE_SQUARE: begin
          case (dir[1:0])
            2'd0:    mv.dx = 2'sd1;
            2'd1:    mv.dy = 2'sd1;
            2'd2:    mv.dx = -2'sd1;
            default: mv.dy = -2'sd1;
          endcase
          mv.back = {1'b0, dir[1:0] + 2'd2};
        end
        MODE_POINTY: begin
          case (dir)
            4'd0:    begin mv.dx = 2'sd1;  mv.dy = -2'sd1; end
            4'd1:    mv.dx = 2'sd1;
            4'd2:    mv.dy = 2'sd1;
            4'd3:    begin mv.dx = -2'sd1; mv.dy = 2'sd1;  end
            4'd4:    mv.dx = -2'sd1;
            default: mv.dy = -2'sd1;
          endcase
          mv.back = (dir[2:0] < 3'd3) ? dir[2:0] + 3'd3 : dir[2:0] - 3'd3;
        end
        MODE_FLAT: begin
          case (dir)
            4'd0:    mv.dx = 2'sd1;
            4'd1:    mv.dy = 2'sd1;
            4'd2:    begin mv.dx = -2'sd1; mv.dy = 2'sd1;  end
            4'd3:    mv.dx = -2'sd1;
            4'd4:    mv.dy = -2'sd1;
            default: begin mv.dx = 2'sd1;  mv.dy = -2'sd1; end
          endcase
          mv.back = (dir[2:0] < 3'd3) ? dir[2:0] + 3'd3 : dir[2:0] - 3'd3;
        end
        default: begin
          if (tri_up) begin
            case (dir)
              4'd0:    begin mv.dx = 2'sd1;  mv.back = 3'd0; end
              4'd1:    begin mv.dy = 2'sd1;  mv.back = 3'd2; end
              default: begin mv.dy = -2'sd1; mv.back = 3'd1; end
            endcase
          end else begin
            case (dir)
              4'd0:    begin mv.dz = -2'sd1; mv.back = 3'd2; end
              4'd1:    begin mv.dx = -2'sd1; mv.back = 3'd1; end
              default: begin mv.dz = 2'sd1;  mv.back = 3'd0; end
            endcase
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/prism_grid_neighbor_step.sv =====
// Prism grid neighbor step: three register stages, one request per cycle while out_stall is low.
// Stage 1 checks the source, stage 2 applies the step, stage 3 checks the
// destination. Each stage advances when its successor is empty or moving.
// Throughput 1 per cycle while out_stall is low. Synchronous active-low reset clears valid bits and config to zero.
// Depends on pgns_pkg and pgns_move.
`default_nettype none
module prism_grid_neighbor_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pgns_pkg::IW-1:0]         cfg_index,
  input  logic [pgns_pkg::CW-1:0]         cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [pgns_pkg::CW-1:0]  in_cell_x,
  input  logic signed [pgns_pkg::CW-1:0]  in_cell_y,
  input  logic signed [pgns_pkg::CW-1:0]  in_cell_z,
  input  logic [pgns_pkg::DW-1:0]         in_direction,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic signed [pgns_pkg::CW-1:0]  out_dest_x,
  output logic signed [pgns_pkg::CW-1:0]  out_dest_y,
  output logic signed [pgns_pkg::CW-1:0]  out_dest_z,
  output logic [pgns_pkg::BW-1:0]         out_back_direction
);
  import pgns_pkg::*;

  grid_mode_t mode_r;
  bounds_t    bnd_r;

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  logic signed [CW-1:0] x1_r, y1_r, z1_r;
  logic [DW-1:0]        d1_r;
  logic                 src_ok1_r, tri_up1_r;
  logic signed [CW+1:0] sum_nxt;

  logic signed [CW-1:0] x2_r, y2_r, z2_r;
  logic [BW-1:0]        back2_r;
  status_t              st2_r;
  move_t                mv;

  status_t              st3_r;
  logic signed [CW-1:0] x3_r, y3_r, z3_r;
  logic [BW-1:0]        back3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SQUARE;
      bnd_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_MODE:   mode_r       <= grid_mode_t'(cfg_data[1:0]);
        REG_BOUNDS_EN:   bnd_r.enabled <= cfg_data[0];
        REG_LOWER_X:     bnd_r.lo_x   <= cfg_data;
        REG_UPPER_X:     bnd_r.hi_x   <= cfg_data;
        REG_LOWER_Y:     bnd_r.lo_y   <= cfg_data;
        REG_UPPER_Y:     bnd_r.hi_y   <= cfg_data;
        REG_LOWER_LAYER: bnd_r.lo_z   <= cfg_data;
        default:         bnd_r.hi_z   <= cfg_data;
      endcase
    end
  end

  assign adv3     = !v3_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  assign sum_nxt = (CW+2)'(in_cell_x) + (CW+2)'(in_cell_y) + (CW+2)'(in_cell_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      x1_r      <= in_cell_x;
      y1_r      <= in_cell_y;
      z1_r      <= in_cell_z;
      d1_r      <= in_direction;
      src_ok1_r <= in_box(bnd_r, in_cell_x, in_cell_y, in_cell_z);
      tri_up1_r <= (sum_nxt == (CW+2)'(1));
    end
  end

  pgns_move u_move (
    .mode   (mode_r),
    .dir    (d1_r),
    .tri_up (tri_up1_r),
    .src_ok (src_ok1_r),
    .mv     (mv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      x2_r    <= x1_r + CW'(mv.dx);
      y2_r    <= y1_r + CW'(mv.dy);
      z2_r    <= z1_r + CW'(mv.dz);
      back2_r <= mv.back;
      st2_r   <= mv.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      z3_r    <= z2_r;
      back3_r <= back2_r;
      if (st2_r == ST_OK && !in_box(bnd_r, x2_r, y2_r, z2_r)) begin
        st3_r <= ST_DST_OUT;
      end else begin
        st3_r <= st2_r;
      end
    end
  end

  assign out_valid          = v3_r;
  assign out_status         = st3_r;
  assign out_dest_x         = x3_r;
  assign out_dest_y         = y3_r;
  assign out_dest_z         = z3_r;
  assign out_back_direction = back3_r;

endmodule
`default_nettype wire

// ===== rtl/core/pgns_checker.sv =====
// Port-level checks for prism_grid_neighbor_step, with its bind.
// Depends on pgns_pkg.
`default_nettype none
module pgns_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      out_status,
  input  logic signed [pgns_pkg::CW-1:0]  out_dest_x,
  input  logic signed [pgns_pkg::CW-1:0]  out_dest_y,
  input  logic signed [pgns_pkg::CW-1:0]  out_dest_z,
  input  logic [pgns_pkg::BW-1:0]         out_back_direction
);
  import pgns_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_dest_x) && $stable(out_dest_y) &&
      $stable(out_dest_z) && $stable(out_status) && $stable(out_back_direction))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_early_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SRC_OUT || out_status == ST_BAD_DIR)
      |-> out_back_direction == '0)
    else $error("rejected request carries a back direction");

endmodule

bind prism_grid_neighbor_step pgns_checker u_pgns_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_dest_x         (out_dest_x),
  .out_dest_y         (out_dest_y),
  .out_dest_z         (out_dest_z),
  .out_back_direction (out_back_direction)
);
`default_nettype wire
